// ===== sv/sctwn_pkg.sv =====
package sctwn_pkg;

	localparam int WaveRamBytes = 16;
	localparam int TimerW       = 22;
	localparam int PosW         = 5;
	localparam int LfsrW        = 16;
	localparam int CfgDataW     = 11;
	localparam int CfgIndexW    = 3;

	localparam logic [11:0]      FreqSpan  = 12'd2048;
	localparam logic [LfsrW-1:0] LfsrSeed  = 16'hFFFF;
	localparam logic [6:0]       DivZero   = 7'd8;

	// bit i of a row is the duty output at step i
	localparam logic [3:0][7:0] DutyRows = '{
		8'b0011_1111,
		8'b1111_0000,
		8'b1100_0000,
		8'b1000_0000
	};

	localparam logic [3:0][2:0] WaveShift = '{3'd2, 3'd1, 3'd0, 3'd4};

	typedef enum logic [1:0] {
		OP_TICK,
		OP_TRIGGER,
		OP_RAM_WRITE,
		OP_DISABLE
	} op_t;

	typedef enum logic [1:0] {
		KIND_SWEEP_PULSE,
		KIND_PULSE,
		KIND_WAVE,
		KIND_NOISE
	} kind_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_CHANNEL_KIND,
		REG_TONE_FREQUENCY,
		REG_DUTY_SELECT,
		REG_WAVE_VOLUME_CODE,
		REG_WAVE_DAC_ON,
		REG_NOISE_DIVISOR_CODE,
		REG_NOISE_SHIFT,
		REG_NOISE_NARROW
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] env_volume;
		logic [3:0] ram_index;
		logic [7:0] ram_byte;
	} in_req_t;

	typedef struct packed {
		logic [3:0] dac_level;
		logic       channel_on;
	} out_rsp_t;

	typedef struct packed {
		logic [1:0]  channel_kind;
		logic [10:0] tone_frequency;
		logic [1:0]  duty_select;
		logic [1:0]  wave_volume_code;
		logic        wave_dac_on;
		logic [2:0]  noise_divisor_code;
		logic [3:0]  noise_shift;
		logic        noise_narrow;
	} cfg_t;

	typedef struct packed {
		logic [3:0]      vol;
		logic [PosW-1:0] pos;
		logic            lfsr_bit;
		logic            enabled;
		logic            fwd;
		logic [7:0]      fwd_byte;
		logic            entry_valid;
	} s1_t;

	function automatic logic [TimerW-1:0] reload_value(cfg_t c);
		logic [6:0]  div;
		logic [11:0] span;
		div  = (c.noise_divisor_code == 3'd0) ? DivZero : {c.noise_divisor_code, 4'b0000};
		span = FreqSpan - {1'b0, c.tone_frequency};
		if (c.channel_kind == KIND_NOISE)
			return {15'd0, div} << c.noise_shift;
		return {8'd0, span, 2'b00};
	endfunction

	function automatic logic [3:0] wave_level(logic [7:0] b, logic odd, logic [1:0] code);
		logic [3:0] nib;
		nib = odd ? b[7:4] : b[3:0];
		return nib >> WaveShift[code];
	endfunction

endpackage

// ===== sv/sctwn_ram.sv =====
module sctwn_ram import sctwn_pkg::*; #(
	parameter int Width = 8,
	parameter int Depth = WaveRamBytes
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sctwn_seq.sv =====
module sctwn_seq import sctwn_pkg::*; #(
	parameter int WAVE_RAM_BYTES = WaveRamBytes
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfg_t                              cfg,
	input  logic                              accept,
	input  in_req_t                           req,
	output logic                              ram_we,
	output logic [$clog2(WAVE_RAM_BYTES)-1:0] ram_waddr,
	output logic [7:0]                        ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(WAVE_RAM_BYTES)-1:0] ram_raddr,
	output s1_t                               s1
);

	localparam int AW = $clog2(WAVE_RAM_BYTES);

	logic                      enabled_q, enabled_n;
	logic [TimerW-1:0]         timer_q, timer_n, timer_dec;
	logic [PosW-1:0]           pos_q, pos_n;
	logic [LfsrW-1:0]          lfsr_q, lfsr_n, lfsr_step;
	logic                      fb;
	logic [WAVE_RAM_BYTES-1:0] wvalid_q;
	logic                      is_write;
	s1_t                       s1_q;

	always_comb begin
		fb        = lfsr_q[0] ^ lfsr_q[1];
		lfsr_step = lfsr_q >> 1;
		lfsr_step[14] = fb;
		if (cfg.noise_narrow)
			lfsr_step[6] = fb;
	end

	always_comb begin
		enabled_n = enabled_q;
		timer_n   = timer_q;
		pos_n     = pos_q;
		lfsr_n    = lfsr_q;
		timer_dec = timer_q - TimerW'(1);
		case (req.opcode)
			OP_TICK: begin
				if (enabled_q && timer_q != '0) begin
					timer_n = timer_dec;
					if (timer_dec == '0) begin
						timer_n = reload_value(cfg);
						pos_n   = pos_q + PosW'(1);
						if (cfg.channel_kind == KIND_NOISE)
							lfsr_n = lfsr_step;
					end
				end
			end
			OP_TRIGGER: begin
				enabled_n = 1'b1;
				lfsr_n    = LfsrSeed;
				timer_n   = reload_value(cfg);
				pos_n     = '0;
			end
			OP_DISABLE: begin
				enabled_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign is_write  = req.opcode == OP_RAM_WRITE;
	assign ram_we    = accept && is_write;
	assign ram_waddr = req.ram_index[AW-1:0];
	assign ram_wdata = req.ram_byte;
	assign ram_re    = accept;
	assign ram_raddr = pos_n[AW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			timer_q   <= '0;
			pos_q     <= '0;
			lfsr_q    <= '0;
			wvalid_q  <= '0;
		end else if (accept) begin
			enabled_q <= enabled_n;
			timer_q   <= timer_n;
			pos_q     <= pos_n;
			lfsr_q    <= lfsr_n;
			if (is_write)
				wvalid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.vol         <= req.env_volume;
			s1_q.pos         <= pos_n;
			s1_q.lfsr_bit    <= lfsr_n[0];
			s1_q.enabled     <= enabled_n;
			s1_q.fwd         <= is_write && ram_waddr == ram_raddr;
			s1_q.fwd_byte    <= req.ram_byte;
			s1_q.entry_valid <= wvalid_q[ram_raddr];
		end
	end

	assign s1 = s1_q;

endmodule

// ===== sv/sctwn_out.sv =====
module sctwn_out import sctwn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     accept,
	input  s1_t      s1,
	input  logic [7:0] rdata,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output out_rsp_t out_rsp
);

	logic       v1_q;
	logic       out_valid_q;
	out_rsp_t   out_rsp_q;
	logic       advance;
	logic [7:0] wave_byte;
	logic [3:0] level;

	assign advance  = v1_q && (!out_valid_q || out_ready);
	assign in_ready = !v1_q || advance;

	always_comb begin
		wave_byte = s1.fwd ? s1.fwd_byte : (s1.entry_valid ? rdata : 8'd0);
		case (cfg.channel_kind)
			KIND_WAVE:
				level = cfg.wave_dac_on ?
					wave_level(wave_byte, s1.pos[0], cfg.wave_volume_code) : 4'd0;
			KIND_NOISE:
				level = s1.lfsr_bit ? 4'd0 : s1.vol;
			default:
				level = DutyRows[cfg.duty_select][s1.pos[2:0]] ? s1.vol : 4'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				v1_q <= 1'b1;
			else if (advance)
				v1_q <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rsp_q.dac_level  <= level;
			out_rsp_q.channel_on <= s1.enabled;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule

// ===== sv/sound_channel_tone_wave_noise_core.sv =====
// Sound channel core: one pulse, wave or noise voice.
// Request channel (in_valid/in_ready/in_req) carries one operation per
// request: tick, trigger, wave RAM byte write or disable, plus the current
// envelope volume. Response channel (out_valid/out_ready/out_rsp) returns
// one response per request: the 4-bit DAC level and the enable flag.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no request is in flight.
// Path: an accepted request is registered into the middle stage (state
// update and wave RAM read), then into the output register.
// Throughput: one request per cycle while out_ready is high; timer, position
// and LFSR update in the accept cycle; wave RAM reads/writes once per cycle.
// Reset: control and channel state clear, data registers do not; wave RAM
// entries read zero until written (one valid bit per byte, no clear pass).
// Stall: while out_ready is low the response holds; one more request is
// taken into the middle stage, then in_ready drops until the output frees.
module sound_channel_tone_wave_noise_core import sctwn_pkg::*; #(
	parameter int WAVE_RAM_BYTES = WaveRamBytes
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_req_t             in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output out_rsp_t            out_rsp,
	input  logic                cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int AW = $clog2(WAVE_RAM_BYTES);

	cfg_t           cfg_q;
	logic           accept;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;
	s1_t            s1;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CHANNEL_KIND:       cfg_q.channel_kind       <= cfg_data[1:0];
				REG_TONE_FREQUENCY:     cfg_q.tone_frequency     <= cfg_data[10:0];
				REG_DUTY_SELECT:        cfg_q.duty_select        <= cfg_data[1:0];
				REG_WAVE_VOLUME_CODE:   cfg_q.wave_volume_code   <= cfg_data[1:0];
				REG_WAVE_DAC_ON:        cfg_q.wave_dac_on        <= cfg_data[0];
				REG_NOISE_DIVISOR_CODE: cfg_q.noise_divisor_code <= cfg_data[2:0];
				REG_NOISE_SHIFT:        cfg_q.noise_shift        <= cfg_data[3:0];
				REG_NOISE_NARROW:       cfg_q.noise_narrow       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sctwn_seq #(
		.WAVE_RAM_BYTES(WAVE_RAM_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.req       (in_req),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.s1        (s1)
	);

	sctwn_ram #(
		.Width(8),
		.Depth(WAVE_RAM_BYTES)
	) u_wave_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sctwn_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.s1        (s1),
		.rdata     (ram_rdata),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

endmodule

// ===== tb/sv/tb_sound_channel_tone_wave_noise_core.sv =====
module tb_sound_channel_tone_wave_noise_core;
	import sctwn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] duty_pattern [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};
	localparam int wave_shift [4] = '{4, 0, 1, 2};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_req_t              in_req = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_rsp_t             out_rsp;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	in_req_t  pending_reqs[$];
	out_rsp_t expected_levels[$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;

	cfg_t              cfg = '0;
	logic              ch_on = 1'b0;
	logic [TimerW-1:0] ch_timer = '0;
	logic [PosW-1:0]   ch_pos = '0;
	logic [LfsrW-1:0]  ch_lfsr = '0;
	logic [7:0]        wave_bytes [WaveRamBytes] = '{default: 8'h00};

	sound_channel_tone_wave_noise_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [TimerW-1:0] timer_period();
		logic [TimerW-1:0] div;
		if (cfg.channel_kind == KIND_NOISE) begin
			div = (cfg.noise_divisor_code == 3'd0) ? TimerW'(8) :
				TimerW'(cfg.noise_divisor_code) << 4;
			return div << cfg.noise_shift;
		end
		return TimerW'(2048 - int'(cfg.tone_frequency)) << 2;
	endfunction

	task automatic advance_channel(input in_req_t req, output out_rsp_t rsp);
		logic       fb;
		logic [7:0] b;
		logic [3:0] nib;
		case (op_t'(req.opcode))
			OP_TICK: begin
				if (ch_on && ch_timer != '0) begin
					ch_timer = ch_timer - TimerW'(1);
					if (ch_timer == '0) begin
						ch_timer = timer_period();
						ch_pos = ch_pos + PosW'(1);
						if (cfg.channel_kind == KIND_NOISE) begin
							fb = ch_lfsr[0] ^ ch_lfsr[1];
							ch_lfsr = ch_lfsr >> 1;
							ch_lfsr[14] = fb;
							if (cfg.noise_narrow)
								ch_lfsr[6] = fb;
						end
					end
				end
			end
			OP_TRIGGER: begin
				ch_on = 1'b1;
				ch_lfsr = '1;
				ch_timer = timer_period();
				ch_pos = '0;
			end
			OP_RAM_WRITE: begin
				wave_bytes[req.ram_index] = req.ram_byte;
			end
			default: begin
				ch_on = 1'b0;
			end
		endcase
		rsp.channel_on = ch_on;
		case (kind_t'(cfg.channel_kind))
			KIND_WAVE: begin
				b = wave_bytes[ch_pos[4:1]];
				nib = ch_pos[0] ? b[7:4] : b[3:0];
				rsp.dac_level = cfg.wave_dac_on ? nib >> wave_shift[cfg.wave_volume_code] : 4'd0;
			end
			KIND_NOISE: begin
				rsp.dac_level = ch_lfsr[0] ? 4'd0 : req.env_volume;
			end
			default: begin
				rsp.dac_level = duty_pattern[cfg.duty_select][ch_pos[2:0]] ? req.env_volume : 4'd0;
			end
		endcase
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(value);
		case (idx)
			REG_CHANNEL_KIND:       cfg.channel_kind = value[1:0];
			REG_TONE_FREQUENCY:     cfg.tone_frequency = value[10:0];
			REG_DUTY_SELECT:        cfg.duty_select = value[1:0];
			REG_WAVE_VOLUME_CODE:   cfg.wave_volume_code = value[1:0];
			REG_WAVE_DAC_ON:        cfg.wave_dac_on = value[0];
			REG_NOISE_DIVISOR_CODE: cfg.noise_divisor_code = value[2:0];
			REG_NOISE_SHIFT:        cfg.noise_shift = value[3:0];
			default:                cfg.noise_narrow = value[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_channel_setup(input cfg_t c);
		write_reg(REG_CHANNEL_KIND, 32'(c.channel_kind));
		write_reg(REG_TONE_FREQUENCY, 32'(c.tone_frequency));
		write_reg(REG_DUTY_SELECT, 32'(c.duty_select));
		write_reg(REG_WAVE_VOLUME_CODE, 32'(c.wave_volume_code));
		write_reg(REG_WAVE_DAC_ON, 32'(c.wave_dac_on));
		write_reg(REG_NOISE_DIVISOR_CODE, 32'(c.noise_divisor_code));
		write_reg(REG_NOISE_SHIFT, 32'(c.noise_shift));
		write_reg(REG_NOISE_NARROW, 32'(c.noise_narrow));
	endtask

	task automatic queue_req(input op_t op, input logic [3:0] vol, input logic [3:0] idx,
			input logic [7:0] data);
		in_req_t r;
		r.opcode = op;
		r.env_volume = vol;
		r.ram_index = idx;
		r.ram_byte = data;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(input op_t op);
		queue_req(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_levels.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// hold the request until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_req <= pending_reqs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		out_rsp_t want;
		if (arst_n && in_valid && in_ready) begin
			advance_channel(in_req, want);
			expected_levels.push_back(want);
		end
	end

	always @(posedge clk) begin
		out_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				$error("unexpected response: dac_level %0d channel_on %0d",
					out_rsp.dac_level, out_rsp.channel_on);
				mismatches++;
			end else begin
				want = expected_levels.pop_front();
				if (out_rsp.dac_level !== want.dac_level) begin
					$error("dac_level: expected %0d, actual %0d", want.dac_level,
						out_rsp.dac_level);
					mismatches++;
				end
				if (out_rsp.channel_on !== want.channel_on) begin
					$error("channel_on: expected %0d, actual %0d", want.channel_on,
						out_rsp.channel_on);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("sound_channel_tone_wave_noise_core test failed");
		$finish;
	end

	initial begin
		cfg_t c;
		int   n_items;
		int   phase;
		int   burst;
		int   r;
		n_items = 0;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_req(OP_TICK, 4'hF, 4'h0, 8'h00);
		queue_req(OP_RAM_WRITE, 4'hF, 4'h0, 8'hFF);
		queue_req(OP_RAM_WRITE, 4'h0, 4'hF, 8'h00);
		wait_drained();

		c = '0;
		c.channel_kind = KIND_PULSE;
		c.tone_frequency = 11'h7FF;
		c.duty_select = 2'd3;
		load_channel_setup(c);
		queue_req(OP_TRIGGER, 4'hF, 4'h0, 8'h00);
		repeat (5) queue_req(OP_TICK, 4'hF, 4'h0, 8'h00);
		queue_req(OP_DISABLE, 4'hF, 4'h0, 8'h00);
		queue_req(OP_TICK, 4'hF, 4'h0, 8'h00);
		wait_drained();

		c.channel_kind = KIND_WAVE;
		c.wave_volume_code = 2'd1;
		c.wave_dac_on = 1'b1;
		load_channel_setup(c);
		queue_req(OP_TRIGGER, 4'h0, 4'h0, 8'h00);
		repeat (4) queue_req(OP_TICK, 4'h0, 4'h0, 8'h00);
		wait_drained();

		c = '0;
		c.channel_kind = KIND_NOISE;
		c.noise_narrow = 1'b1;
		load_channel_setup(c);
		queue_req(OP_TRIGGER, 4'h9, 4'h0, 8'h00);
		repeat (8) queue_req(OP_TICK, 4'h9, 4'h0, 8'h00);

		while (n_items < 1000) begin
			wait_drained();
			if (n_items < 333) begin
				send_idle_pct = 22;
				recv_idle_pct = 73;
			end else if (n_items < 666) begin
				send_idle_pct = 73;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 0) begin
				c = '1;
			end else if (phase == 1) begin
				c = '0;
			end else begin
				c.channel_kind = 2'($urandom_range(0, 3));
				c.tone_frequency = ($urandom_range(0, 99) < 80) ?
					11'($urandom_range(2036, 2047)) : 11'($urandom_range(0, 2047));
				c.duty_select = 2'($urandom_range(0, 3));
				c.wave_volume_code = 2'($urandom_range(0, 3));
				c.wave_dac_on = $urandom_range(0, 99) < 85;
				c.noise_divisor_code = ($urandom_range(0, 99) < 70) ?
					3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
				c.noise_shift = ($urandom_range(0, 99) < 75) ?
					4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
				c.noise_narrow = 1'($urandom_range(0, 1));
			end
			load_channel_setup(c);
			burst = $urandom_range(40, 120);
			if ($urandom_range(0, 99) < 75) begin
				queue_random(OP_TRIGGER);
				n_items++;
			end
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < 82)
					queue_random(OP_TICK);
				else if (r < 89)
					queue_random(OP_RAM_WRITE);
				else if (r < 95)
					queue_random(OP_TRIGGER);
				else
					queue_random(OP_DISABLE);
				n_items++;
			end
			phase++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_levels.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("sound_channel_tone_wave_noise_core test passed");
		else
			$display("sound_channel_tone_wave_noise_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sctwn_pkg.sv
sv/sctwn_ram.sv
sv/sctwn_seq.sv
sv/sctwn_out.sv
sv/sound_channel_tone_wave_noise_core.sv
tb/sv/tb_sound_channel_tone_wave_noise_core.sv
